// ----- rtl/rvde_pkg.sv -----
// Package for the RV32IM decode/execute core: opcodes, codes, shared structs.
// No dependencies.
package rvde_pkg;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INST_MRET   = 32'h3020_0073;

    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;
    localparam logic [31:0] CAUSE_ECALL = 32'h0000_000B;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_KIND    = 2'd3;

    localparam logic CMD_INST = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [1:0] RESET_PC_ADDR = 2'd0;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic [1:0]  status;
        logic [31:0] halt_code;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic        exec;      // execute the captured item (single cycle)
        logic        div_start; // launch the divider
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_div;
        logic div_busy;
    } stat_t;

endpackage

// ----- rtl/rv32im_decode_execute_core.sv -----
// RV32IM decode/execute core top level: stream ports, APB config, output register.
// Depends on rvde_pkg, rvde_control, rvde_datapath, rvde_divider.
//
// One input transfer gives one output transfer. An item is captured, then
// executed; divide and remainder first start the one-bit-per-cycle divider
// and wait until it is done. A result not yet taken holds back the
// execute step of the next item. The result sits in an output register, so
// the next item is taken while that result waits to be taken. reset_pc is a
// readable register; reset returns it to its default and the PC starts from
// that value, so a write does not move the PC.
module rv32im_decode_execute_core
    import rvde_pkg::*;
#(
    parameter int REG_COUNT = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // instruction[31:0], load_data[63:32]
    input  logic         s_tuser,  // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // next_pc, mem_kind, mem_size, mem_address,
                                   // mem_write_data, status, halt_code, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0] reset_pc_reg;
    logic        cmd_reg;
    logic [31:0] inst_reg, ld_reg;
    logic        capture, load_out, out_free;
    logic        mvalid_reg;
    result_t     res, res_reg;
    cmd_t        ctl;
    stat_t       stat;

    assign pready = 1'b1;
    assign prdata = (paddr == RESET_PC_ADDR) ? reset_pc_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_pc_reg <= 32'h8000_0000;
        else if (psel && penable && pwrite && paddr == RESET_PC_ADDR)
            reset_pc_reg <= pwdata;
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cmd_reg  <= s_tuser;
            inst_reg <= s_tdata[31:0];
            ld_reg   <= s_tdata[63:32];
        end
        if (load_out)
            res_reg <= res;
    end

    assign out_free = !mvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (load_out)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    rvde_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .capture(capture), .load_out(load_out), .out_free(out_free),
        .stat(stat), .ctl(ctl)
    );

    rvde_datapath #(.REG_COUNT(REG_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .reset_pc(reset_pc_reg),
        .item_cmd(cmd_reg), .item_inst(inst_reg), .item_ld(ld_reg),
        .ctl(ctl), .stat(stat), .result(res)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, res_reg.halt_code, res_reg.status,
                       res_reg.mem_write_data, res_reg.mem_address,
                       res_reg.mem_size, res_reg.mem_kind, res_reg.next_pc};

endmodule

// ----- rtl/rvde_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses rvde_pkg (none of its items beyond style); standalone unit.
module rvde_divider
    import rvde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = (cnt_reg != 6'd0);
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ----- rtl/rvde_datapath.sv -----
// Datapath: register file, PC, CSRs, decode, ALU, multiplier, divider.
// Depends on rvde_pkg and rvde_divider.
module rvde_datapath
    import rvde_pkg::*;
#(
    parameter int REG_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] reset_pc,
    input  logic        item_cmd,
    input  logic [31:0] item_inst,
    input  logic [31:0] item_ld,
    input  cmd_t        ctl,
    output stat_t       stat,
    output result_t     result
);

    logic [31:0] rf_reg [1:REG_COUNT-1];
    logic [31:0] pc_reg, mtvec_reg, mepc_reg, mstatus_reg, mcause_reg;
    logic        lpend_reg;
    logic [4:0]  ltgt_reg;
    logic [2:0]  lfmt_reg;

    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, a7v, a0v;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

    function automatic logic [31:0] rd_rf(input logic [4:0] i,
                                          input logic [31:0] f [1:REG_COUNT-1]);
        logic [31:0] v;
        v = '0;
        for (int k = 1; k < REG_COUNT; k++)
            if (i == 5'(k))
                v = f[k];
        return v;
    endfunction

    assign opc   = item_inst[6:0];
    assign rd    = item_inst[11:7];
    assign f3    = item_inst[14:12];
    assign rs1   = item_inst[19:15];
    assign rs2   = item_inst[24:20];
    assign f7    = item_inst[31:25];
    assign a     = rd_rf(rs1, rf_reg);
    assign b     = rd_rf(rs2, rf_reg);
    assign a7v   = rd_rf(5'd17, rf_reg);
    assign a0v   = rd_rf(5'd10, rf_reg);
    assign imm_i = {{20{item_inst[31]}}, item_inst[31:20]};
    assign imm_s = {{20{item_inst[31]}}, item_inst[31:25], item_inst[11:7]};
    assign imm_b = {{20{item_inst[31]}}, item_inst[7], item_inst[30:25],
                    item_inst[11:8], 1'b0};
    assign imm_j = {{12{item_inst[31]}}, item_inst[19:12], item_inst[20],
                    item_inst[30:21], 1'b0};
    assign imm_u = {item_inst[31:12], 12'h000};

    // multiplier: 33x33 signed, split in halves would be typical; one 32x32
    // core with sign correction keeps it within a single multiplier
    logic [63:0] pu;
    logic [31:0] mulh_val;
    assign pu = {32'h0, a} * {32'h0, b};
    assign mulh_val = pu[63:32] - (a[31] ? b : 32'h0) - (b[31] ? a : 32'h0);

    // divider operands in magnitude form
    logic        div_signed, div_neg_q, div_neg_r, div_busy;
    logic [31:0] dv_a, dv_b, dq, dr;
    logic        negq_reg, negr_reg, rem_reg, dz_reg, ovf_reg;
    logic [31:0] da_reg;
    assign div_signed = ~f3[0];
    assign div_neg_q  = div_signed & (a[31] ^ b[31]);
    assign div_neg_r  = div_signed & a[31];
    assign dv_a = (div_signed & a[31]) ? -a : a;
    assign dv_b = (div_signed & b[31]) ? -b : b;

    rvde_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
        .dividend(dv_a), .divisor(dv_b),
        .busy(div_busy), .quotient(dq), .remainder(dr)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            negq_reg <= div_neg_q;
            negr_reg <= div_neg_r;
            rem_reg  <= f3[1];
            dz_reg   <= (b == 32'h0);
            ovf_reg  <= div_signed & (a == 32'h8000_0000) & (b == 32'hFFFF_FFFF);
            da_reg   <= a;
        end
    end

    logic [31:0] div_val;
    always_comb
    begin
        if (dz_reg)
            div_val = rem_reg ? da_reg : 32'hFFFF_FFFF;
        else if (ovf_reg)
            div_val = rem_reg ? 32'h0 : 32'h8000_0000;
        else if (rem_reg)
            div_val = negr_reg ? -dr : dr;
        else
            div_val = negq_reg ? -dq : dq;
    end

    assign stat.needs_div = (item_cmd == CMD_INST) && !lpend_reg && (opc == OPC_OP)
                            && (f7 == 7'h01) && f3[2];
    assign stat.div_busy  = div_busy;

    // main execute
    logic        ok, wr_en, t;
    logic [31:0] wr_val, npc, csr_old, csr_new;
    logic [1:0]  csr_sel;
    logic        csr_hit;
    result_t     res;

    always_comb
    begin
        ok      = 1'b1;
        wr_en   = 1'b0;
        wr_val  = '0;
        t       = 1'b0;
        npc     = pc_reg + 32'd4;
        csr_hit = 1'b1;
        csr_sel = 2'd0;
        csr_old = '0;
        csr_new = '0;
        res     = '0;
        case (item_inst[31:20])
            CSR_MTVEC:   begin csr_sel = 2'd0; csr_old = mtvec_reg;   end
            CSR_MEPC:    begin csr_sel = 2'd1; csr_old = mepc_reg;    end
            CSR_MSTATUS: begin csr_sel = 2'd2; csr_old = mstatus_reg; end
            CSR_MCAUSE:  begin csr_sel = 2'd3; csr_old = mcause_reg;  end
            default:     csr_hit = 1'b0;
        endcase
        csr_new = (f3 == 3'd1) ? a : (csr_old | a);
        if (item_cmd == CMD_LOAD || lpend_reg)
        begin
            npc = pc_reg;
            if (!(item_cmd == CMD_LOAD && lpend_reg))
                res.status = ST_KIND;
        end
        else
        begin
            case (opc)
                OPC_LUI:   begin wr_en = 1'b1; wr_val = imm_u; end
                OPC_AUIPC: begin wr_en = 1'b1; wr_val = pc_reg + imm_u; end
                OPC_JAL:
                begin
                    wr_en = 1'b1; wr_val = pc_reg + 32'd4; npc = pc_reg + imm_j;
                end
                OPC_JALR:
                begin
                    if (f3 != 3'd0)
                        ok = 1'b0;
                    else
                    begin
                        wr_en = 1'b1; wr_val = pc_reg + 32'd4;
                        npc = (a + imm_i) & ~32'h1;
                    end
                end
                OPC_BRANCH:
                begin
                    case (f3)
                        3'd0: t = (a == b);
                        3'd1: t = (a != b);
                        3'd4: t = ($signed(a) < $signed(b));
                        3'd5: t = !($signed(a) < $signed(b));
                        3'd6: t = (a < b);
                        3'd7: t = (a >= b);
                        default: ok = 1'b0;
                    endcase
                    if (t)
                        npc = pc_reg + imm_b;
                end
                OPC_LOAD:
                begin
                    if (f3 inside {3'd3, 3'd6, 3'd7})
                        ok = 1'b0;
                    else
                    begin
                        res.mem_kind = KIND_READ;
                        res.mem_size = f3[1:0];
                        res.mem_address = a + imm_i;
                    end
                end
                OPC_STORE:
                begin
                    if (f3 > 3'd2)
                        ok = 1'b0;
                    else
                    begin
                        res.mem_kind = KIND_WRITE;
                        res.mem_size = f3[1:0];
                        res.mem_address = a + imm_s;
                        res.mem_write_data = b;
                    end
                end
                OPC_IMM:
                begin
                    wr_en = 1'b1;
                    case (f3)
                        3'd0: wr_val = a + imm_i;
                        3'd2: wr_val = {31'h0, $signed(a) < $signed(imm_i)};
                        3'd3: wr_val = {31'h0, a < imm_i};
                        3'd4: wr_val = a ^ imm_i;
                        3'd6: wr_val = a | imm_i;
                        3'd7: wr_val = a & imm_i;
                        3'd1:
                        begin
                            if (f7 != 7'h00) ok = 1'b0;
                            wr_val = a << rs2;
                        end
                        default:
                        begin
                            if (f7 == 7'h00) wr_val = a >> rs2;
                            else if (f7 == 7'h20) wr_val = 32'($signed(a) >>> rs2);
                            else ok = 1'b0;
                        end
                    endcase
                end
                OPC_OP:
                begin
                    wr_en = 1'b1;
                    if (f7 == 7'h00)
                    begin
                        case (f3)
                            3'd0: wr_val = a + b;
                            3'd1: wr_val = a << b[4:0];
                            3'd2: wr_val = {31'h0, $signed(a) < $signed(b)};
                            3'd3: wr_val = {31'h0, a < b};
                            3'd4: wr_val = a ^ b;
                            3'd5: wr_val = a >> b[4:0];
                            3'd6: wr_val = a | b;
                            default: wr_val = a & b;
                        endcase
                    end
                    else if (f7 == 7'h20)
                    begin
                        if (f3 == 3'd0) wr_val = a - b;
                        else if (f3 == 3'd5) wr_val = 32'($signed(a) >>> b[4:0]);
                        else ok = 1'b0;
                    end
                    else if (f7 == 7'h01)
                    begin
                        case (f3)
                            3'd0: wr_val = pu[31:0];
                            3'd1: wr_val = mulh_val;
                            3'd3: wr_val = pu[63:32];
                            3'd2: ok = 1'b0;
                            default: wr_val = div_val;
                        endcase
                    end
                    else
                        ok = 1'b0;
                end
                OPC_FENCE:
                begin
                    if (f3 != 3'd0) ok = 1'b0;
                end
                OPC_SYSTEM:
                begin
                    if (item_inst == INST_ECALL)
                        npc = mtvec_reg;
                    else if (item_inst == INST_EBREAK)
                    begin
                        res.status = ST_HALT; res.halt_code = a0v; npc = pc_reg;
                    end
                    else if (item_inst == INST_MRET)
                        npc = mepc_reg;
                    else if ((f3 == 3'd1 || f3 == 3'd2) && csr_hit)
                    begin
                        wr_en = 1'b1; wr_val = csr_old;
                    end
                    else
                        ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase
            if (!ok)
            begin
                res = '0;
                res.status = ST_ILLEGAL;
                npc = pc_reg;
                wr_en = 1'b0;
            end
        end
        res.next_pc = npc;
    end

    logic is_inst;
    assign is_inst = (item_cmd == CMD_INST) && !lpend_reg;

    logic [31:0] ld_val;
    always_comb
    begin
        case (lfmt_reg)
            3'd0:    ld_val = {{24{item_ld[7]}}, item_ld[7:0]};
            3'd1:    ld_val = {{16{item_ld[15]}}, item_ld[15:0]};
            3'd4:    ld_val = {24'h0, item_ld[7:0]};
            3'd5:    ld_val = {16'h0, item_ld[15:0]};
            default: ld_val = item_ld;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k < REG_COUNT; k++)
                rf_reg[k] <= '0;
            pc_reg      <= reset_pc;
            mtvec_reg   <= '0;
            mepc_reg    <= '0;
            mstatus_reg <= '0;
            mcause_reg  <= '0;
            lpend_reg   <= 1'b0;
            ltgt_reg    <= '0;
            lfmt_reg    <= '0;
        end
        else if (ctl.exec)
        begin
            if (item_cmd == CMD_LOAD && lpend_reg)
            begin
                lpend_reg <= 1'b0;
                for (int k = 1; k < REG_COUNT; k++)
                    if (ltgt_reg == 5'(k))
                        rf_reg[k] <= ld_val;
            end
            else if (is_inst)
            begin
                pc_reg <= npc;
                if (wr_en)
                    for (int k = 1; k < REG_COUNT; k++)
                        if (rd == 5'(k))
                            rf_reg[k] <= wr_val;
                if (ok && opc == OPC_LOAD)
                begin
                    lpend_reg <= 1'b1;
                    ltgt_reg  <= rd;
                    lfmt_reg  <= f3;
                end
                if (ok && opc == OPC_SYSTEM)
                begin
                    if (item_inst == INST_ECALL)
                    begin
                        mepc_reg   <= pc_reg;
                        mcause_reg <= (a7v == 32'hFFFF_FFFF) ? CAUSE_ECALL : 32'h0;
                    end
                    else if (item_inst != INST_EBREAK && item_inst != INST_MRET)
                    begin
                        case (csr_sel)
                            2'd0:    mtvec_reg   <= csr_new;
                            2'd1:    mepc_reg    <= csr_new;
                            2'd2:    mstatus_reg <= csr_new;
                            default: mcause_reg  <= csr_new;
                        endcase
                    end
                end
            end
        end
    end

    assign result = res;

endmodule

// ----- rtl/rvde_control.sv -----
// Controller: input capture, divider wait and output register handshake.
// Depends on rvde_pkg.
module rvde_control
    import rvde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  capture,
    output logic  load_out,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        capture    = 1'b0;
        load_out   = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    capture    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.needs_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (out_free)
                begin
                    ctl.exec   = 1'b1;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy && out_free)
                begin
                    ctl.exec         = 1'b1;
                    load_out         = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> load_out) else $error("exec without output load");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |=> state_reg == S_DIV) else $error("divider not awaited");
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> state_reg == S_EXEC) else $error("capture lost");

endmodule
